@@ rtl/tts_pkg.sv @@
package tts_pkg;

  localparam int DATA_W    = 32;
  localparam int NUM_W     = 64;
  localparam int WIDE_W    = 66;
  localparam int FRAC_W    = 16;
  localparam int ROW_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIAG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd2;

  localparam logic signed [DATA_W-1:0] DIAG_RESET  = 32'sh0002_0000;
  localparam logic signed [DATA_W-1:0] LOWER_RESET = 32'shFFFF_0000;
  localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'shFFFF_0000;
  localparam logic signed [DATA_W-1:0] SAT_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MUL_LU,
    MUL_LD,
    MUL_UU
  } mul_sel_e;

  typedef enum logic [1:0] {
    NUM_PROD,
    NUM_LAST,
    NUM_BACK
  } num_sel_e;

  typedef enum logic {
    DEN_PREV,
    DEN_READ
  } den_sel_e;

  typedef struct packed {
    logic             in_load;
    logic             mul_en;
    mul_sel_e         mul_sel;
    logic             start_a;
    num_sel_e         num_sel;
    den_sel_e         den_sel;
    logic             start_b;
    logic             num_load;
    logic             row0_wr;
    logic             fwd_wr;
    logic             u_load;
    logic             out_load;
    logic             final_row;
    logic [ROW_W-1:0] row;
  } tts_cmd_t;

  typedef struct packed {
    logic last;
    logic busy;
    logic out_free;
  } tts_status_t;

  function automatic logic sat_ovf(input logic [WIDE_W-1:0] x);
    return !((&x[WIDE_W-1:DATA_W-1]) || !(|x[WIDE_W-1:DATA_W-1]));
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic [WIDE_W-1:0] x);
    logic [DATA_W-1:0] r;
    if (sat_ovf(x)) begin
      r = x[WIDE_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/tts_div.sv @@
module tts_div
  import tts_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [NUM_W-1:0]  num_i,
  input  logic signed [DATA_W-1:0] den_i,
  output logic                     busy_o,
  output logic signed [NUM_W-1:0]  quo_o,
  output logic                     dz_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             run_q, run_d;
  logic             fix_q, fix_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [NUM_W-1:0]  mag_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] den_q;
  logic              neg_q;
  logic              dz_q;
  logic              nz_q;
  logic              nneg_q;
  logic signed [NUM_W-1:0] quo_q;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [NUM_W-1:0]  num_abs;
  logic [DATA_W-1:0] den_abs;

  assign num_abs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign den_abs = den_i[DATA_W-1] ? DATA_W'(-den_i) : DATA_W'(den_i);

  assign trial = {rem_q, mag_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    run_d = run_q;
    fix_d = 1'b0;
    cnt_d = cnt_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
    end else if (run_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        run_d = 1'b0;
        fix_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fix_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      fix_q <= fix_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= num_abs;
      rem_q  <= '0;
      den_q  <= den_abs;
      neg_q  <= num_i[NUM_W-1] ^ den_i[DATA_W-1];
      dz_q   <= (den_i == '0);
      nz_q   <= (num_i != '0);
      nneg_q <= num_i[NUM_W-1];
    end else if (run_q) begin
      rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      mag_q <= {mag_q[NUM_W-2:0], ge};
    end
    if (fix_q) begin
      if (dz_q) begin
        if (!nz_q) begin
          quo_q <= '0;
        end else if (nneg_q) begin
          quo_q <= NUM_W'(SAT_MIN);
        end else begin
          quo_q <= NUM_W'(SAT_MAX);
        end
      end else begin
        quo_q <= neg_q ? NUM_W'(-mag_q) : NUM_W'(mag_q);
      end
    end
  end

  assign busy_o = run_q | fix_q;
  assign quo_o  = quo_q;
  assign dz_o   = dz_q;

endmodule

@@ rtl/tts_datapath.sv @@
module tts_datapath
  import tts_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic signed [DATA_W-1:0] rhs_value_i,
  input  logic                     last_row_i,
  input  logic                     out_stall_i,
  input  tts_cmd_t                 cmd_i,
  output tts_status_t              status_o,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] solution_o,
  output logic [ROW_W-1:0]         row_index_o,
  output logic                     final_out_o,
  output logic                     fault_o
);

  localparam int AW = $clog2(MAX_ROWS);

  logic signed [DATA_W-1:0] diag_q, lower_q, upper_q;
  logic signed [DATA_W-1:0] rhs_q;
  logic                     last_q;
  logic signed [DATA_W-1:0] prev_p_q, prev_d_q;
  logic signed [DATA_W-1:0] rd_p_q, rd_d_q;
  logic signed [DATA_W-1:0] u_q;
  logic signed [NUM_W-1:0]  prod_q, num_q;
  logic                     fault_q, fault_d;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] sol_q;
  logic [ROW_W-1:0]         row_q;
  logic                     final_q;
  logic                     fault_out_q;

  logic [DATA_W-1:0] pivot_mem [MAX_ROWS];
  logic [DATA_W-1:0] rhs_mem   [MAX_ROWS];

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [NUM_W-1:0]  prod_d;
  logic signed [NUM_W-1:0]  num_a;
  logic signed [DATA_W-1:0] den_a;
  logic signed [NUM_W-1:0]  last_shift, rd_shift;
  logic signed [NUM_W-1:0]  quo_a, quo_b;
  logic                     busy_a, busy_b, dz_a, dz_b;
  logic signed [WIDE_W-1:0] piv_wide, d_wide, u_wide;
  logic [DATA_W-1:0]        wr_p, wr_d;
  logic                     mem_we;
  logic [AW-1:0]            addr;
  logic                     out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_q  <= DIAG_RESET;
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DIAG:  diag_q  <= cfg_data_i;
        REG_LOWER: lower_q <= cfg_data_i;
        REG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_LU: begin
        mul_a = lower_q;
        mul_b = upper_q;
      end
      MUL_LD: begin
        mul_a = lower_q;
        mul_b = prev_d_q;
      end
      MUL_UU: begin
        mul_a = upper_q;
        mul_b = u_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  assign last_shift = NUM_W'(prev_d_q) <<< FRAC_W;
  assign rd_shift   = NUM_W'(rd_d_q) <<< FRAC_W;

  always_comb begin
    unique case (cmd_i.num_sel)
      NUM_PROD: num_a = prod_q;
      NUM_LAST: num_a = last_shift;
      NUM_BACK: num_a = num_q;
      default:  num_a = '0;
    endcase
    den_a = (cmd_i.den_sel == DEN_READ) ? rd_p_q : prev_p_q;
  end

  tts_div u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_a),
    .num_i   (num_a),
    .den_i   (den_a),
    .busy_o  (busy_a),
    .quo_o   (quo_a),
    .dz_o    (dz_a)
  );

  tts_div u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_b),
    .num_i   (prod_q),
    .den_i   (prev_p_q),
    .busy_o  (busy_b),
    .quo_o   (quo_b),
    .dz_o    (dz_b)
  );

  assign piv_wide = WIDE_W'(diag_q) - WIDE_W'(quo_a);
  assign d_wide   = WIDE_W'(rhs_q) - WIDE_W'(quo_b);
  assign u_wide   = WIDE_W'(quo_a);

  assign mem_we = cmd_i.row0_wr | cmd_i.fwd_wr;
  assign wr_p   = cmd_i.row0_wr ? diag_q : sat32(piv_wide);
  assign wr_d   = cmd_i.row0_wr ? rhs_q : sat32(d_wide);
  assign addr   = cmd_i.row[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pivot_mem[addr] <= wr_p;
      rhs_mem[addr]   <= wr_d;
    end
    rd_p_q <= pivot_mem[addr];
    rd_d_q <= rhs_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      rhs_q <= rhs_value_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.num_load) begin
      num_q <= rd_shift - prod_q;
    end
    if (mem_we) begin
      prev_p_q <= wr_p;
      prev_d_q <= wr_d;
    end
    if (cmd_i.u_load) begin
      u_q <= sat32(u_wide);
    end
    if (cmd_i.out_load) begin
      sol_q       <= u_q;
      row_q       <= cmd_i.row;
      final_q     <= cmd_i.final_row;
      fault_out_q <= fault_q;
    end
  end

  always_comb begin
    fault_d = fault_q;
    if (cmd_i.fwd_wr) begin
      fault_d = fault_q | dz_a | dz_b | sat_ovf(piv_wide) | sat_ovf(d_wide);
    end
    if (cmd_i.u_load) begin
      fault_d = fault_q | dz_a | sat_ovf(u_wide);
    end
    if (cmd_i.out_load && cmd_i.final_row) begin
      fault_d = 1'b0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fault_q <= fault_d;
      if (cmd_i.in_load) begin
        last_q <= last_row_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.last     = last_q;
  assign status_o.busy     = busy_a | busy_b;
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign solution_o  = sol_q;
  assign row_index_o = row_q;
  assign final_out_o = final_q;
  assign fault_o     = fault_out_q;

endmodule

@@ rtl/tts_ctrl.sv @@
module tts_ctrl
  import tts_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tts_status_t status_i,
  output tts_cmd_t    cmd_o
);

  localparam int AW = $clog2(MAX_ROWS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ROW0   = 4'd1;
  localparam logic [3:0] S_FMUL1  = 4'd2;
  localparam logic [3:0] S_FMUL2  = 4'd3;
  localparam logic [3:0] S_FSTB   = 4'd4;
  localparam logic [3:0] S_FWAIT  = 4'd5;
  localparam logic [3:0] S_FUPD   = 4'd6;
  localparam logic [3:0] S_BLAST  = 4'd7;
  localparam logic [3:0] S_BWAIT  = 4'd8;
  localparam logic [3:0] S_BSAT   = 4'd9;
  localparam logic [3:0] S_BPUSH  = 4'd10;
  localparam logic [3:0] S_BRD    = 4'd11;
  localparam logic [3:0] S_BMUL   = 4'd12;
  localparam logic [3:0] S_BSUB   = 4'd13;
  localparam logic [3:0] S_BSTART = 4'd14;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          end_row;

  // the top row closes the system even without the last flag
  assign end_row = status_i.last || (idx_q == AW'(MAX_ROWS - 1));

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_LU;
    cmd_o.num_sel   = NUM_PROD;
    cmd_o.den_sel   = DEN_PREV;
    cmd_o.row       = ROW_W'(idx_q);
    cmd_o.final_row = (idx_q == '0);
    state_d         = state_q;
    idx_d           = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = (idx_q == '0) ? S_ROW0 : S_FMUL1;
        end
      end
      S_ROW0, S_FUPD: begin
        cmd_o.row0_wr = (state_q == S_ROW0);
        cmd_o.fwd_wr  = (state_q == S_FUPD);
        if (end_row) begin
          state_d = S_BLAST;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_IDLE;
        end
      end
      S_FMUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LU;
        state_d       = S_FMUL2;
      end
      S_FMUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LD;
        cmd_o.start_a = 1'b1;
        cmd_o.num_sel = NUM_PROD;
        cmd_o.den_sel = DEN_PREV;
        state_d       = S_FSTB;
      end
      S_FSTB: begin
        cmd_o.start_b = 1'b1;
        state_d       = S_FWAIT;
      end
      S_FWAIT: begin
        if (!status_i.busy) begin
          state_d = S_FUPD;
        end
      end
      S_BLAST: begin
        cmd_o.start_a = 1'b1;
        cmd_o.num_sel = NUM_LAST;
        cmd_o.den_sel = DEN_PREV;
        state_d       = S_BWAIT;
      end
      S_BWAIT: begin
        if (!status_i.busy) begin
          state_d = S_BSAT;
        end
      end
      S_BSAT: begin
        cmd_o.u_load = 1'b1;
        state_d      = S_BPUSH;
      end
      S_BPUSH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = S_BRD;
          end
        end
      end
      S_BRD: begin
        state_d = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_UU;
        state_d       = S_BSUB;
      end
      S_BSUB: begin
        cmd_o.num_load = 1'b1;
        state_d        = S_BSTART;
      end
      S_BSTART: begin
        cmd_o.start_a = 1'b1;
        cmd_o.num_sel = NUM_BACK;
        cmd_o.den_sel = DEN_READ;
        state_d       = S_BWAIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_a |-> !status_i.busy)
    else $error("divider started while busy");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result item loaded over an unread one");

  a_solve_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.final_row) |=> (state_q == S_IDLE && idx_q == '0))
    else $error("solver not cleared after row zero");

  a_upd_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fwd_wr || cmd_o.u_load) |-> !status_i.busy)
    else $error("quotient used before divider finished");

endmodule

@@ rtl/tridiagonal_thomas_solver.sv @@
// Thomas-algorithm solver for a constant-coefficient tridiagonal system in
// Q16.16. Right-hand side items arrive in row order; each row runs forward
// elimination (two radix-2 dividers of 64 steps, started in successive
// states, each with a sign-fix step, plus multiply and update steps),
// except row 0, which is stored directly. The item with last_row set (or row
// MAX_ROWS-1) starts back substitution, which emits the solution from the
// last row down to row 0, each item with one pass of the 64-step divider.
// Results saturate and fault reports a zero pivot or saturation seen so far
// in the solve. The user must write coefficients through the cfg port only
// while the block is idle; the block itself does not enforce this.
module tridiagonal_thomas_solver
  import tts_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] rhs_value_i,
  input  logic                     last_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] solution_o,
  output logic [ROW_W-1:0]         row_index_o,
  output logic                     final_out_o,
  output logic                     fault_o
);

  tts_cmd_t    cmd;
  tts_status_t status;

  assign cfg_ready_o = 1'b1;

  tts_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tts_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rhs_value_i (rhs_value_i),
    .last_row_i  (last_row_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .solution_o  (solution_o),
    .row_index_o (row_index_o),
    .final_out_o (final_out_o),
    .fault_o     (fault_o)
  );

endmodule

@@ verif/tts_solution_checker.sv @@
module tts_solution_checker
  import tts_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [DATA_W-1:0] rhs_value_i,
  input  logic                     last_row_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] solution_i,
  input  logic [ROW_W-1:0]         row_index_i,
  input  logic                     final_out_i,
  input  logic                     fault_i,
  output int                       mismatch_count_o,
  output int                       results_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNIT = longint'(1) << FRAC_W;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [ROW_W-1:0]         row;
    logic                     row0;
    logic                     fault;
  } solution_t;

  solution_t                pending_solutions[$];
  logic signed [DATA_W-1:0] diag_q;
  logic signed [DATA_W-1:0] lower_q;
  logic signed [DATA_W-1:0] upper_q;
  logic signed [DATA_W-1:0] pivots[MAX_ROWS];
  logic signed [DATA_W-1:0] mod_rhs[MAX_ROWS];
  int                       rows_in;
  logic                     solve_fault;
  int                       mismatches;

  function automatic logic signed [DATA_W-1:0] clamp_q16(input longint x);
    logic signed [DATA_W-1:0] r;
    if (x > longint'(SAT_MAX)) begin
      solve_fault = 1'b1;
      r = SAT_MAX;
    end else if (x < longint'(SAT_MIN)) begin
      solve_fault = 1'b1;
      r = SAT_MIN;
    end else begin
      r = DATA_W'(x);
    end
    return r;
  endfunction

  // q32.32 numerator over a q16.16 pivot, truncated toward zero
  function automatic longint pivot_quot(input longint num, input logic signed [DATA_W-1:0] den);
    longint r;
    if (den == 0) begin
      solve_fault = 1'b1;
      if (num > 0) begin
        r = longint'(SAT_MAX);
      end else if (num < 0) begin
        r = longint'(SAT_MIN);
      end else begin
        r = 0;
      end
    end else begin
      r = num / longint'(den);
    end
    return r;
  endfunction

  task automatic eliminate_row(input logic signed [DATA_W-1:0] rhs, input logic last);
    int                       r;
    int                       i;
    longint                   num;
    logic signed [DATA_W-1:0] u;
    r = (rows_in > MAX_ROWS - 1) ? MAX_ROWS - 1 : rows_in;
    if (r == 0) begin
      pivots[0] = diag_q;
      mod_rhs[0] = rhs;
    end else begin
      pivots[r] = clamp_q16(longint'(diag_q)
                  - pivot_quot(longint'(lower_q) * longint'(upper_q), pivots[r-1]));
      mod_rhs[r] = clamp_q16(longint'(rhs)
                   - pivot_quot(longint'(lower_q) * longint'(mod_rhs[r-1]), pivots[r-1]));
    end
    if (!last && r < MAX_ROWS - 1) begin
      rows_in = r + 1;
    end else begin
      // back substitution, last row first
      u = clamp_q16(pivot_quot(longint'(mod_rhs[r]) * UNIT, pivots[r]));
      for (i = r; i >= 0; i--) begin
        if (i < r) begin
          num = longint'(mod_rhs[i]) * UNIT - longint'(upper_q) * longint'(u);
          u = clamp_q16(pivot_quot(num, pivots[i]));
        end
        pending_solutions.push_back('{u, ROW_W'(i), i == 0, solve_fault});
      end
      rows_in = 0;
      solve_fault = 1'b0;
    end
  endtask

  task automatic check_solution();
    solution_t want;
    if (pending_solutions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected solution item row %0d value %h final %b fault %b",
                 $realtime, row_index_i, solution_i, final_out_i, fault_i);
      end
    end else begin
      want = pending_solutions.pop_front();
      if (solution_i !== want.value || row_index_i !== want.row ||
          final_out_i !== want.row0 || fault_i !== want.fault) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: solution item expected %h row %0d final %b fault %b",
                   $realtime, want.value, want.row, want.row0, want.fault);
          $display("%0t: solution item actual   %h row %0d final %b fault %b",
                   $realtime, solution_i, row_index_i, final_out_i, fault_i);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_q = DIAG_RESET;
      lower_q = LOWER_RESET;
      upper_q = UPPER_RESET;
      rows_in = 0;
      solve_fault = 1'b0;
      mismatches = 0;
      pending_solutions.delete();
      mismatch_count_o <= 0;
      results_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DIAG: diag_q = cfg_data_i;
          REG_LOWER: lower_q = cfg_data_i;
          REG_UPPER: upper_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        check_solution();
      end
      if (in_valid_i && !in_stall_i) begin
        eliminate_row(rhs_value_i, last_row_i);
      end
      mismatch_count_o <= mismatches;
      results_pending_o <= pending_solutions.size();
    end
  end

endmodule

@@ verif/tridiagonal_thomas_solver_test.sv @@
module tridiagonal_thomas_solver_test
  import tts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = 64;
  localparam int SETTLE_CYCLES = 160;
  localparam int RANDOM_ROWS = 190;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] rhs_value;
  logic                     last_row;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] solution;
  logic [ROW_W-1:0]         row_index;
  logic                     final_out;
  logic                     fault;
  logic                     steady;
  int                       mismatches;
  int                       pending;

  tridiagonal_thomas_solver #(
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rhs_value_i (rhs_value),
    .last_row_i  (last_row),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .solution_o  (solution),
    .row_index_o (row_index),
    .final_out_o (final_out),
    .fault_o     (fault)
  );

  tts_solution_checker #(
    .MAX_ROWS(MAX_ROWS)
  ) solution_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .rhs_value_i       (rhs_value),
    .last_row_i        (last_row),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .solution_i        (solution),
    .row_index_i       (row_index),
    .final_out_i       (final_out),
    .fault_i           (fault),
    .mismatch_count_o  (mismatches),
    .results_pending_o (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 16);
  end

  function automatic logic signed [DATA_W-1:0] pick_rhs();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(4))
          0: v = SAT_MAX;
          1: v = SAT_MIN;
          2: v = '0;
          3: v = 32'sd1;
          default: v = -32'sd1;
        endcase
      end
      default: v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_coef(
    input logic signed [DATA_W-1:0] centre,
    input int                       spread
  );
    int                       offset;
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(19))
      0: v = $urandom;
      1: v = SAT_MAX;
      2: v = SAT_MIN;
      3: v = '0;
      default: begin
        offset = int'($urandom_range(0, 2 * spread)) - spread;
        v = centre + offset;
      end
    endcase
    return v;
  endfunction

  task automatic send_rhs(input logic signed [DATA_W-1:0] value, input logic last);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rhs_value <= value;
    last_row <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_system(input int rows, input logic mark_last);
    int k;
    for (k = 0; k < rows; k++) begin
      send_rhs(pick_rhs(), mark_last && (k == rows - 1));
    end
  endtask

  task automatic drain_solutions();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] index,
                            input logic signed [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_coefs(input logic signed [DATA_W-1:0] diag,
                           input logic signed [DATA_W-1:0] lower,
                           input logic signed [DATA_W-1:0] upper);
    drain_solutions();
    write_coef(REG_DIAG, diag);
    write_coef(REG_LOWER, lower);
    write_coef(REG_UPPER, upper);
  endtask

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int sent;
    int phase;
    int rows;
    int phase_rows;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    rhs_value <= '0;
    last_row <= 1'b0;
    steady <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients, extreme right-hand sides
    send_rhs('0, 1'b1);
    send_rhs(SAT_MAX, 1'b1);
    send_rhs(SAT_MIN, 1'b1);
    send_rhs(SAT_MAX, 1'b0);
    send_rhs(SAT_MIN, 1'b1);
    send_rhs(32'sh0001_0000, 1'b0);
    send_rhs(-32'sh0001_0000, 1'b0);
    send_rhs(32'sh0001_8000, 1'b1);

    // zero pivot: positive, negative and zero numerator, then in elimination
    set_coefs('0, SAT_MAX, SAT_MIN);
    send_rhs(32'sh0001_0000, 1'b1);
    send_rhs(-32'sh0001_0000, 1'b1);
    send_rhs('0, 1'b1);
    send_rhs(32'sh0001_0000, 1'b0);
    send_rhs(32'sh0002_0000, 1'b1);

    // tiny pivot forces saturation, plus a write to the unused index
    set_coefs(32'sd1, SAT_MIN, SAT_MAX);
    write_coef(REG_SPARE, '1);
    send_rhs(SAT_MAX, 1'b1);
    send_rhs(SAT_MIN, 1'b0);
    send_rhs(SAT_MAX, 1'b0);
    send_rhs(32'sh0000_7fff, 1'b1);

    // negative diagonal, asymmetric off-diagonals
    set_coefs(-32'sh0002_0000, 32'sh0000_8000, 32'sh0003_0000);
    send_rhs(32'sh0005_0000, 1'b0);
    send_rhs(-32'sh0000_4000, 1'b1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ROWS) begin
      steady <= (phase == 3);
      if (phase == 2) begin
        set_coefs(DIAG_RESET, LOWER_RESET, UPPER_RESET);
        // no last flag: the final row closes the system
        send_system(MAX_ROWS, 1'b0);
        sent += MAX_ROWS;
      end
      set_coefs(pick_coef(32'sh0003_0000, 32'h0001_0000),
                pick_coef('0, 32'h0001_0000),
                pick_coef('0, 32'h0001_0000));
      phase_rows = 0;
      while (phase_rows < 24) begin
        rows = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        send_system(rows, 1'b1);
        phase_rows += rows;
        if ($urandom_range(5) == 0) begin
          drain_solutions();
        end
      end
      sent += phase_rows;
      phase++;
    end
    drain_solutions();

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
